### src/hrhp_pkg.sv
// hrhp_pkg: shared constants, the summary record and character tables
// for the http response header parser; no dependencies
package hrhp_pkg;

  localparam int unsigned MAX_LEN  = 65535;
  localparam int unsigned POS_W    = $clog2(MAX_LEN + 1);
  localparam int unsigned KEY_LEN  = 15;
  localparam int unsigned MIN_LINE = 12;
  localparam int unsigned QDEPTH   = 2;
  localparam int unsigned QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_9   = 8'h39;
  localparam logic [7:0] CH_C   = 8'h43;

  // per-message summary handed from the scanner to the result stage
  typedef struct packed {
    logic             ok;
    logic [9:0]       status;
    logic [POS_W-1:0] hdr_idx;
    logic [POS_W:0]   msg_len;
    logic             len_present;
    logic [POS_W-1:0] len_value;
  } rec_t;

  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = "C";
      4'd1:    c = "o";
      4'd2:    c = "n";
      4'd3:    c = "t";
      4'd4:    c = "e";
      4'd5:    c = "n";
      4'd6:    c = "t";
      4'd7:    c = "-";
      4'd8:    c = "L";
      4'd9:    c = "e";
      4'd10:   c = "n";
      4'd11:   c = "g";
      4'd12:   c = "t";
      4'd13:   c = "h";
      4'd14:   c = ":";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = "H";
      3'd1:    c = "T";
      3'd2:    c = "T";
      3'd3:    c = "P";
      3'd4:    c = "/";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### src/hrhp_front.sv
// hrhp_front: byte scanner, status line and content-length matchers
// depends on hrhp_pkg; emits one rec_t summary on the last byte
module hrhp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          msg_byte_i,
  input  logic                last_byte_i,
  output hrhp_pkg::rec_t      rec_o
);

  localparam logic [2:0] LP_PREFIX = 3'd0;
  localparam logic [2:0] LP_SEEK   = 3'd1;
  localparam logic [2:0] LP_D1     = 3'd2;
  localparam logic [2:0] LP_D2     = 3'd3;
  localparam logic [2:0] LP_D3     = 3'd4;
  localparam logic [2:0] LP_READ   = 3'd5;
  localparam logic [2:0] LP_BAD    = 3'd6;
  localparam logic [2:0] LP_CLOSED = 3'd7;

  localparam logic [1:0] KP_SEARCH = 2'd0;
  localparam logic [1:0] KP_BLANKS = 2'd1;
  localparam logic [1:0] KP_DIGITS = 2'd2;
  localparam logic [1:0] KP_DONE   = 2'd3;

  localparam int unsigned PW   = hrhp_pkg::POS_W;
  localparam int unsigned LV_W = PW + 4;

  logic [PW-1:0] pos_q, pos_d;
  logic          ovf_q, ovf_d;
  logic [23:0]   recent_q, recent_d;
  logic          hdr_found_q, hdr_found_d;
  logic [PW-1:0] hdr_idx_q, hdr_idx_d;
  logic [2:0]    lphase_q, lphase_d;
  logic [9:0]    status_q, status_d;
  logic          status_good_q, status_good_d;
  logic [3:0]    kcnt_q, kcnt_d;
  logic [1:0]    kphase_q, kphase_d;
  logic [PW-1:0] lval_q, lval_d;
  logic          lpres_q, lpres_d;

  logic          is_dig;
  logic [3:0]    dig;
  logic          crlf;
  logic [9:0]    status_mul;
  logic [LV_W-1:0] lv_ext, lv_mul;

  always_comb begin
    pos_d         = pos_q;
    ovf_d         = ovf_q;
    hdr_found_d   = hdr_found_q;
    hdr_idx_d     = hdr_idx_q;
    lphase_d      = lphase_q;
    status_d      = status_q;
    status_good_d = status_good_q;
    kcnt_d        = kcnt_q;
    kphase_d      = kphase_q;
    lval_d        = lval_q;
    lpres_d       = lpres_q;

    is_dig     = (msg_byte_i >= hrhp_pkg::CH_0) && (msg_byte_i <= hrhp_pkg::CH_9);
    dig        = 4'(msg_byte_i - hrhp_pkg::CH_0);
    crlf       = (msg_byte_i == hrhp_pkg::CH_LF) && (recent_q[7:0] == hrhp_pkg::CH_CR) &&
                 (pos_q != '0);
    status_mul = (status_q << 3) + (status_q << 1) + {6'b0, dig};
    lv_ext     = LV_W'(lval_q);
    lv_mul     = (lv_ext << 3) + (lv_ext << 1) + LV_W'(dig);

    if (pos_q == PW'(hrhp_pkg::MAX_LEN)) begin
      ovf_d = 1'b1;
    end

    // first line
    if (lphase_q != LP_CLOSED) begin
      if (crlf) begin
        status_good_d = (lphase_q == LP_READ) && (pos_q >= PW'(hrhp_pkg::MIN_LINE + 1));
        lphase_d      = LP_CLOSED;
      end else begin
        unique case (lphase_q) inside
          LP_PREFIX: begin
            if ((pos_q < PW'(5)) && (msg_byte_i == hrhp_pkg::prefix_char(pos_q[2:0]))) begin
              lphase_d = (pos_q == PW'(4)) ? LP_SEEK : LP_PREFIX;
            end else begin
              lphase_d = LP_BAD;
            end
          end
          LP_SEEK: begin
            if (msg_byte_i == hrhp_pkg::CH_SP) begin
              lphase_d = LP_D1;
            end
          end
          LP_D1, LP_D2, LP_D3: begin
            if (is_dig) begin
              status_d = status_mul;
              lphase_d = lphase_q + 3'd1;
            end else begin
              lphase_d = LP_BAD;
            end
          end
          default: begin
          end
        endcase
      end
    end

    // header end and content-length key
    if (!hdr_found_q) begin
      if ((msg_byte_i == hrhp_pkg::CH_LF) &&
          (recent_q == {hrhp_pkg::CH_CR, hrhp_pkg::CH_LF, hrhp_pkg::CH_CR}) &&
          (pos_q >= PW'(3))) begin
        hdr_found_d = 1'b1;
        hdr_idx_d   = pos_q - PW'(3);
      end else begin
        unique case (kphase_q)
          KP_SEARCH: begin
            if ((kcnt_q < 4'(hrhp_pkg::KEY_LEN)) &&
                (msg_byte_i == hrhp_pkg::key_char(kcnt_q))) begin
              kcnt_d = kcnt_q + 4'd1;
              if (kcnt_q == 4'(hrhp_pkg::KEY_LEN - 1)) begin
                kphase_d = KP_BLANKS;
              end
            end else begin
              kcnt_d = (msg_byte_i == hrhp_pkg::CH_C) ? 4'd1 : 4'd0;
            end
          end
          KP_BLANKS: begin
            if ((msg_byte_i == hrhp_pkg::CH_SP) || (msg_byte_i == hrhp_pkg::CH_TAB)) begin
              kphase_d = KP_BLANKS;
            end else if (is_dig) begin
              lpres_d  = 1'b1;
              lval_d   = PW'(dig);
              kphase_d = KP_DIGITS;
            end else begin
              kphase_d = KP_DONE;
            end
          end
          KP_DIGITS: begin
            if (is_dig) begin
              lval_d = (lv_mul > LV_W'(hrhp_pkg::MAX_LEN)) ? PW'(hrhp_pkg::MAX_LEN)
                                                           : lv_mul[PW-1:0];
            end else begin
              kphase_d = KP_DONE;
            end
          end
          default: begin
          end
        endcase
      end
    end

    recent_d = {recent_q[15:0], msg_byte_i};
    if (pos_q != PW'(hrhp_pkg::MAX_LEN)) begin
      pos_d = pos_q + PW'(1);
    end
  end

  always_comb begin
    rec_o.ok          = !ovf_d && hdr_found_d && status_good_d;
    rec_o.status      = status_d;
    rec_o.hdr_idx     = hdr_idx_d;
    rec_o.msg_len     = {1'b0, pos_q} + (PW + 1)'(1);
    rec_o.len_present = lpres_d;
    rec_o.len_value   = lval_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q         <= '0;
      ovf_q         <= 1'b0;
      recent_q      <= '0;
      hdr_found_q   <= 1'b0;
      hdr_idx_q     <= '0;
      lphase_q      <= LP_PREFIX;
      status_q      <= '0;
      status_good_q <= 1'b0;
      kcnt_q        <= '0;
      kphase_q      <= KP_SEARCH;
      lval_q        <= '0;
      lpres_q       <= 1'b0;
    end else if (accept_i) begin
      if (last_byte_i) begin
        pos_q         <= '0;
        ovf_q         <= 1'b0;
        recent_q      <= '0;
        hdr_found_q   <= 1'b0;
        hdr_idx_q     <= '0;
        lphase_q      <= LP_PREFIX;
        status_q      <= '0;
        status_good_q <= 1'b0;
        kcnt_q        <= '0;
        kphase_q      <= KP_SEARCH;
        lval_q        <= '0;
        lpres_q       <= 1'b0;
      end else begin
        pos_q         <= pos_d;
        ovf_q         <= ovf_d;
        recent_q      <= recent_d;
        hdr_found_q   <= hdr_found_d;
        hdr_idx_q     <= hdr_idx_d;
        lphase_q      <= lphase_d;
        status_q      <= status_d;
        status_good_q <= status_good_d;
        kcnt_q        <= kcnt_d;
        kphase_q      <= kphase_d;
        lval_q        <= lval_d;
        lpres_q       <= lpres_d;
      end
    end
  end

endmodule

### src/hrhp_queue.sv
// hrhp_queue: short queue of message summaries between scanner and result stage
// depends on hrhp_pkg for rec_t and the queue depth
module hrhp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hrhp_pkg::rec_t wdata_i,
  output logic           full_o,
  input  logic           pop_i,
  output hrhp_pkg::rec_t rdata_o,
  output logic           valid_o
);

  localparam int unsigned D  = hrhp_pkg::QDEPTH;
  localparam int unsigned PW = hrhp_pkg::QPTR_W;
  localparam int unsigned CW = hrhp_pkg::QCNT_W;

  hrhp_pkg::rec_t mem_q [D];
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == CW'(D));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(D - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(D - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

### src/hrhp_back.sv
// hrhp_back: body offset and length computation and the result register
// depends on hrhp_pkg for rec_t
module hrhp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  hrhp_pkg::rec_t rec_i,
  input  logic           rec_valid_i,
  output logic           rec_pop_o,
  output logic           empty_o,
  input  logic           pop_i,
  output logic           parse_ok_o,
  output logic [9:0]     status_code_o,
  output logic [15:0]    body_offset_o,
  output logic [15:0]    body_length_o
);

  localparam int unsigned LW = hrhp_pkg::POS_W + 1;

  logic          out_valid_q, out_valid_d;
  logic          ok_q;
  logic [9:0]    status_q;
  logic [15:0]   offset_q;
  logic [15:0]   length_q;
  logic          load;
  logic [LW-1:0] bo_raw, bo, bl;

  assign empty_o       = !out_valid_q;
  assign parse_ok_o    = ok_q;
  assign status_code_o = status_q;
  assign body_offset_o = offset_q;
  assign body_length_o = length_q;

  assign load      = rec_valid_i && (!out_valid_q || pop_i);
  assign rec_pop_o = load;

  always_comb begin
    bo_raw = LW'(rec_i.hdr_idx) + LW'(4);
    bo     = (bo_raw > rec_i.msg_len) ? rec_i.msg_len : bo_raw;
    bl     = rec_i.msg_len - bo;
    if (rec_i.len_present && (LW'(rec_i.len_value) < bl)) begin
      bl = LW'(rec_i.len_value);
    end
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ok_q     <= rec_i.ok;
      status_q <= rec_i.ok ? rec_i.status : 10'd0;
      offset_q <= rec_i.ok ? 16'(bo) : 16'd0;
      length_q <= rec_i.ok ? 16'(bl) : 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### src/http_response_header_parser.sv
// http_response_header_parser: top level, scanner -> summary queue -> result stage
// depends on hrhp_pkg, hrhp_front, hrhp_queue, hrhp_back
//
// channel   direction  handshake       payload
// message   in         push / full     msg_byte_i, last_byte_i
// result    out        empty / pop     parse_ok_o, status_code_o, body_offset_o, body_length_o
//
// one byte per cycle while full is low; every byte updates the scanner state in the cycle it is taken
// a finished summary is written into the queue, then loaded into the result register when it is free
// two summaries queue behind the result register; full rises only when all are held
// reset clears all scanner, queue and output control state; no clearing pass
module http_response_header_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  msg_byte_i,
  input  logic        last_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic        parse_ok_o,
  output logic [9:0]  status_code_o,
  output logic [15:0] body_offset_o,
  output logic [15:0] body_length_o
);

  hrhp_pkg::rec_t front_rec;
  hrhp_pkg::rec_t queue_rec;
  logic           accept;
  logic           queue_valid;
  logic           queue_pop;

  assign accept = push && !full;

  hrhp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .msg_byte_i  (msg_byte_i),
    .last_byte_i (last_byte_i),
    .rec_o       (front_rec)
  );

  hrhp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept && last_byte_i),
    .wdata_i (front_rec),
    .full_o  (full),
    .pop_i   (queue_pop),
    .rdata_o (queue_rec),
    .valid_o (queue_valid)
  );

  hrhp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rec_i         (queue_rec),
    .rec_valid_i   (queue_valid),
    .rec_pop_o     (queue_pop),
    .empty_o       (empty),
    .pop_i         (pop),
    .parse_ok_o    (parse_ok_o),
    .status_code_o (status_code_o),
    .body_offset_o (body_offset_o),
    .body_length_o (body_length_o)
  );

endmodule

### src/hrhp_checker.sv
// hrhp_checker: port-level assertions for http_response_header_parser
// bound to the top level; no package dependencies
module hrhp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push,
  input logic        full,
  input logic [7:0]  msg_byte_i,
  input logic        last_byte_i,
  input logic        empty,
  input logic        pop,
  input logic        parse_ok_o,
  input logic [9:0]  status_code_o,
  input logic [15:0] body_offset_o,
  input logic [15:0] body_length_o
);

  // a waiting result transaction holds until popped
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(parse_ok_o) && $stable(status_code_o) &&
                       $stable(body_offset_o) && $stable(body_length_o))
    else $error("result changed while stalled");

  // failed parse reports all fields as zero
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !parse_ok_o |-> status_code_o == 10'd0 && body_offset_o == 16'd0 &&
                              body_length_o == 16'd0)
    else $error("nonzero fields on failed parse");

  // status is three decimal digits
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> status_code_o <= 10'd999)
    else $error("status out of range");

  // body lies within the message
  a_body_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && parse_ok_o |-> body_offset_o >= 16'd4 &&
      (17'(body_offset_o) + 17'(body_length_o)) <= 17'd65536)
    else $error("body outside message");

endmodule

bind http_response_header_parser hrhp_checker u_hrhp_checker (.*);

### verif/tb_http_response_header_parser.sv
// tb_http_response_header_parser: self-checking testbench for the http response header parser
// drives byte-wide messages through the push / full side and checks every result against a header scan
// tracker or a directed row's expectation; depends on hrhp_pkg and http_response_header_parser
`timescale 1ns / 1ps

module tb_http_response_header_parser;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned RANDOM_BYTES   = 1100;
  localparam int unsigned MIN_RANDOM     = 12;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam logic [39:0]  HTTP_PREFIX = "HTTP/";
  localparam logic [119:0] LENGTH_KEY  = "Content-Length:";

  typedef logic [7:0] octet_t;

  typedef enum logic [2:0] {
    LN_PREFIX, LN_SEEK, LN_DIGIT1, LN_DIGIT2, LN_DIGIT3, LN_CODE, LN_BAD, LN_CLOSED
  } line_state_e;

  typedef enum logic [1:0] {
    KY_SEARCH, KY_BLANKS, KY_DIGITS, KY_DONE
  } key_state_e;

  typedef struct packed {
    logic        ok;
    logic [9:0]  code;
    logic [15:0] boff;
    logic [15:0] blen;
  } parse_res_t;

  typedef struct {
    string text;
    bit    typed;
    bit    ok;
    int    code;
    int    boff;
    int    blen;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  msg_byte_i;
  logic        last_byte_i;
  logic        empty;
  logic        pop;
  logic        parse_ok_o;
  logic [9:0]  status_code_o;
  logic [15:0] body_offset_o;
  logic [15:0] body_length_o;

  // tracker state for the message in flight
  logic [hrhp_pkg::POS_W-1:0] cur_pos;
  logic             past_limit;
  logic [23:0]      last_three;
  logic             hdr_found;
  logic [15:0]      hdr_idx;
  line_state_e      line_st;
  logic [9:0]       code_acc;
  logic             line_ok;
  logic [3:0]       key_cnt;
  key_state_e       key_st;
  logic [15:0]      clen_acc;
  logic             clen_seen;

  parse_res_t parse_results_due[$];
  int         mismatches    = 0;
  int         n_bytes       = 0;
  int         n_msgs        = 0;
  int         n_ok          = 0;
  int         n_clen        = 0;
  int         snd_idle_pct  = 0;
  int         rcv_idle_pct  = 0;
  int         quiet_cycles  = 0;
  bit         long_hold_req = 1'b0;

  dir_row_t directed_rows [17] = '{
    '{"HTTP/1.0 200 OK||", 1'b1, 1'b1, 200, 19, 0},
    '{"HTTP/1.1 404 Not Found|Content-Length: 5||hello", 1'b1, 1'b1, 404, 45, 5},
    '{"HTTP/1.1 200 OK|Content-Length: 99||abc", 1'b1, 1'b1, 200, 39, 3},
    '{"HTTP/1.1 200 OK|Content-Length: x|Content-Length: 2||abcd", 1'b0, 1'b0, 0, 0, 0},
    '{"HTTP/1.1 200 OK||Content-Length: 1", 1'b0, 1'b0, 0, 0, 0},
    '{"HTTP/1.1 200 OK|Content-Length: 3|", 1'b1, 1'b0, 0, 0, 0},
    '{"HTTQ/1.1 200 OK||", 1'b1, 1'b0, 0, 0, 0},
    '{"HTTP/1 200||", 1'b1, 1'b0, 0, 0, 0},
    '{"HTTP/1.1 2x0 Fine||", 1'b1, 1'b0, 0, 0, 0},
    '{"HTTP/1.0 503 Service|Content-Length: \t 123456789||body", 1'b0, 1'b0, 0, 0, 0},
    '{"HTTP/1.0 301 Moved|content-length: 1||xyz", 1'b0, 1'b0, 0, 0, 0},
    '{"HTTP/1.1 100 Continue|CContent-Length:7||0123456789", 1'b0, 1'b0, 0, 0, 0},
    '{"H", 1'b1, 1'b0, 0, 0, 0},
    '{"||", 1'b1, 1'b0, 0, 0, 0},
    '{"HTTP/1.1 999 Max Status||tail", 1'b0, 1'b0, 0, 0, 0},
    '{"HTTP/1.0 000 Zero Code|Content-Length: 0||x", 1'b0, 1'b0, 0, 0, 0},
    '{"HTTP/1.1  200 Two Spaces||", 1'b0, 1'b0, 0, 0, 0}
  };

  http_response_header_parser i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .msg_byte_i    (msg_byte_i),
    .last_byte_i   (last_byte_i),
    .empty         (empty),
    .pop           (pop),
    .parse_ok_o    (parse_ok_o),
    .status_code_o (status_code_o),
    .body_offset_o (body_offset_o),
    .body_length_o (body_length_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit is_dec(input octet_t b);
    return (b >= hrhp_pkg::CH_0) && (b <= hrhp_pkg::CH_9);
  endfunction

  function automatic void clear_tracker();
    cur_pos    = '0;
    past_limit = 1'b0;
    last_three = '0;
    hdr_found  = 1'b0;
    hdr_idx    = '0;
    line_st    = LN_PREFIX;
    code_acc   = '0;
    line_ok    = 1'b0;
    key_cnt    = '0;
    key_st     = KY_SEARCH;
    clen_acc   = '0;
    clen_seen  = 1'b0;
  endfunction

  function automatic void parse_step(input octet_t b, input logic lst);
    logic [hrhp_pkg::POS_W-1:0] pos;
    logic             crlf;
    int unsigned      acc;
    int unsigned      msg_len;
    int unsigned      off;
    int unsigned      blen;
    parse_res_t       res;
    pos  = cur_pos;
    crlf = (b == hrhp_pkg::CH_LF) && (last_three[7:0] == hrhp_pkg::CH_CR) && (pos >= 1);
    if (pos >= hrhp_pkg::MAX_LEN) past_limit = 1'b1;

    if (line_st != LN_CLOSED) begin
      if (crlf) begin
        line_ok = (line_st == LN_CODE) && (int'(pos) - 1 >= int'(hrhp_pkg::MIN_LINE));
        line_st = LN_CLOSED;
      end else begin
        case (line_st)
          LN_PREFIX: begin
            line_st = LN_BAD;
            if (pos < 5) begin
              if (b == HTTP_PREFIX[39 - 8 * int'(pos) -: 8])
                line_st = (pos == 4) ? LN_SEEK : LN_PREFIX;
            end
          end
          LN_SEEK: begin
            if (b == hrhp_pkg::CH_SP) line_st = LN_DIGIT1;
          end
          LN_DIGIT1, LN_DIGIT2, LN_DIGIT3: begin
            if (is_dec(b)) begin
              code_acc = code_acc * 10 + (b - hrhp_pkg::CH_0);
              line_st  = line_state_e'(line_st + 3'd1);
            end else begin
              line_st = LN_BAD;
            end
          end
          default: ;
        endcase
      end
    end

    if (!hdr_found) begin
      if (b == hrhp_pkg::CH_LF &&
          last_three == {hrhp_pkg::CH_CR, hrhp_pkg::CH_LF, hrhp_pkg::CH_CR} && pos >= 3) begin
        hdr_found = 1'b1;
        hdr_idx   = pos - 3;
      end else begin
        case (key_st)
          KY_SEARCH: begin
            if (key_cnt < hrhp_pkg::KEY_LEN &&
                b == LENGTH_KEY[119 - 8 * int'(key_cnt) -: 8]) begin
              key_cnt++;
              if (key_cnt == hrhp_pkg::KEY_LEN) key_st = KY_BLANKS;
            end else begin
              key_cnt = (b == hrhp_pkg::CH_C) ? 4'd1 : 4'd0;
            end
          end
          KY_BLANKS: begin
            if (b != hrhp_pkg::CH_SP && b != hrhp_pkg::CH_TAB) begin
              if (is_dec(b)) begin
                clen_seen = 1'b1;
                clen_acc  = 16'(b - hrhp_pkg::CH_0);
                key_st    = KY_DIGITS;
              end else begin
                key_st = KY_DONE;
              end
            end
          end
          KY_DIGITS: begin
            if (is_dec(b)) begin
              acc      = clen_acc * 10 + (b - hrhp_pkg::CH_0);
              clen_acc = (acc > hrhp_pkg::MAX_LEN) ? 16'(hrhp_pkg::MAX_LEN) : 16'(acc);
            end else begin
              key_st = KY_DONE;
            end
          end
          default: ;
        endcase
      end
    end

    last_three = {last_three[15:0], b};
    if (cur_pos < hrhp_pkg::MAX_LEN) cur_pos++;

    if (lst) begin
      msg_len = int'(pos) + 1;
      res     = '0;
      if (!past_limit && hdr_found && line_ok) begin
        off = hdr_idx + 4;
        if (off > msg_len) off = msg_len;
        blen = msg_len - off;
        if (clen_seen && clen_acc < blen) blen = clen_acc;
        res.ok   = 1'b1;
        res.code = code_acc;
        res.boff = 16'(off);
        res.blen = 16'(blen);
        n_ok++;
        if (clen_seen) n_clen++;
      end
      parse_results_due.push_back(res);
      n_msgs++;
      clear_tracker();
    end
  endfunction

  // '|' stands for a line break in message text
  function automatic void append_text(ref octet_t m[$], input string s);
    for (int i = 0; i < s.len(); i++) begin
      if (s[i] == "|") begin
        m.push_back(hrhp_pkg::CH_CR);
        m.push_back(hrhp_pkg::CH_LF);
      end else begin
        m.push_back(s[i]);
      end
    end
  endfunction

  function automatic void add_length_field(ref octet_t m[$], input int tail_len);
    case ($urandom_range(0, 9))
      0:       append_text(m, "content-length:");
      1:       append_text(m, "CContent-Length:");
      2:       append_text(m, "Content-Lenth:");
      default: append_text(m, "Content-Length:");
    endcase
    repeat ($urandom_range(0, 3))
      m.push_back($urandom_range(0, 1) ? hrhp_pkg::CH_SP : hrhp_pkg::CH_TAB);
    case ($urandom_range(0, 7))
      0:       ;
      1:       append_text(m, $sformatf("%0d", $urandom_range(0, 99999999)));
      2:       append_text(m, $sformatf("%0d", $urandom_range(0, 9)));
      default: append_text(m, $sformatf("%0d", tail_len + 3 - int'($urandom_range(0, 6))));
    endcase
    if ($urandom_range(0, 3) == 0) append_text(m, " x");
    append_text(m, "|");
  endfunction

  function automatic void build_response(ref octet_t m[$]);
    int roll;
    int tail_len;
    int n_hdr;
    int key_at;
    roll     = $urandom_range(0, 99);
    tail_len = $urandom_range(0, 40);
    m.delete();
    if (roll < 10) begin
      repeat ($urandom_range(1, 30)) m.push_back(octet_t'($urandom));
      return;
    end
    append_text(m, "HTTP/");
    if (roll < 16) m[$urandom_range(0, 4)] = octet_t'($urandom);
    case ($urandom_range(0, 3))
      0:       append_text(m, "1.0");
      1:       append_text(m, "1.1");
      2:       append_text(m, "1");
      default: ;
    endcase
    repeat (($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : 1) m.push_back(hrhp_pkg::CH_SP);
    for (int k = 0; k < 3; k++)
      m.push_back((roll < 22 && k == 1) ? octet_t'($urandom)
                                        : octet_t'(hrhp_pkg::CH_0 + $urandom_range(0, 9)));
    if ($urandom_range(0, 3) != 0) begin
      m.push_back(hrhp_pkg::CH_SP);
      repeat ($urandom_range(0, 10)) m.push_back(octet_t'(8'h61 + $urandom_range(0, 25)));
    end
    append_text(m, "|");
    n_hdr  = $urandom_range(0, 3);
    key_at = ($urandom_range(0, 9) < 7) ? $urandom_range(0, n_hdr) : -1;
    for (int h = 0; h <= n_hdr; h++) begin
      if (h == key_at) begin
        add_length_field(m, tail_len);
      end else if (h < n_hdr) begin
        append_text(m, "X-");
        repeat ($urandom_range(1, 6)) m.push_back(octet_t'(8'h61 + $urandom_range(0, 25)));
        append_text(m, ": ");
        repeat ($urandom_range(0, 8)) m.push_back(octet_t'(8'h41 + $urandom_range(0, 25)));
        append_text(m, "|");
      end
    end
    if ($urandom_range(0, 9) == 0) add_length_field(m, tail_len);
    if (roll >= 28 || roll < 22) append_text(m, "|");
    repeat (tail_len) m.push_back(octet_t'($urandom));
  endfunction

  function automatic void shuffle_idle();
    int pick [3] = '{0, 6, 30};
    snd_idle_pct = pick[$urandom_range(0, 2)];
    rcv_idle_pct = pick[$urandom_range(0, 2)];
  endfunction

  task automatic send_byte(input octet_t b, input logic lst);
    int gap;
    if ($urandom_range(0, 99) < snd_idle_pct) begin
      gap = $urandom_range(1, 16);
      @(negedge clk_i);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    push        <= 1'b1;
    msg_byte_i  <= b;
    last_byte_i <= lst;
    @(posedge clk_i);
    while (full !== 1'b0) @(posedge clk_i);
    n_bytes++;
    parse_step(b, lst);
  endtask

  task automatic send_message(input octet_t m[$]);
    for (int i = 0; i < m.size(); i++) send_byte(m[i], i == m.size() - 1);
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    pop       = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD;
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else if ($urandom_range(0, 99) < rcv_idle_pct) begin
        pop       <= 1'b0;
        hold_left = $urandom_range(0, 15);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    parse_res_t want;
    if (rst_ni && pop && !empty) begin
      if (parse_results_due.size() == 0) begin
        $error("unexpected result: parse_ok %0d status %0d offset %0d length %0d",
               parse_ok_o, status_code_o, body_offset_o, body_length_o);
        mismatches++;
      end else begin
        want = parse_results_due.pop_front();
        if (parse_ok_o !== want.ok) begin
          $error("parse_ok: expected %0d, got %0d", want.ok, parse_ok_o);
          mismatches++;
        end
        if (status_code_o !== want.code) begin
          $error("status_code: expected %0d, got %0d", want.code, status_code_o);
          mismatches++;
        end
        if (body_offset_o !== want.boff) begin
          $error("body_offset: expected %0d, got %0d", want.boff, body_offset_o);
          mismatches++;
        end
        if (body_length_o !== want.blen) begin
          $error("body_length: expected %0d, got %0d", want.blen, body_length_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("http_response_header_parser: mismatch");
      $finish;
    end
  end

  initial begin
    octet_t msg[$];
    int     rand_start;
    int     n_random;
    rst_ni      = 1'b0;
    push        = 1'b0;
    msg_byte_i  = '0;
    last_byte_i = 1'b0;
    n_random    = 0;
    clear_tracker();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[r]) begin
      shuffle_idle();
      msg.delete();
      append_text(msg, directed_rows[r].text);
      send_message(msg);
      if (directed_rows[r].typed)
        parse_results_due[parse_results_due.size() - 1] = '{directed_rows[r].ok,
          10'(directed_rows[r].code), 16'(directed_rows[r].boff), 16'(directed_rows[r].blen)};
    end

    // drain, then fill the result queue behind a long receiver hold-off
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    @(negedge clk_i);
    push <= 1'b0;
    while (parse_results_due.size() != 0) @(posedge clk_i);
    long_hold_req = 1'b1;
    repeat (10) begin
      msg.delete();
      append_text(msg, $sformatf("HTTP/1.1 %0d Ok||%0d", $urandom_range(100, 599),
                                 $urandom_range(0, 999)));
      send_message(msg);
    end

    rand_start = n_bytes;
    while (n_bytes - rand_start < RANDOM_BYTES || n_random < MIN_RANDOM) begin
      if (n_bytes - rand_start >= RANDOM_BYTES * 4 / 5) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end else begin
        shuffle_idle();
      end
      build_response(msg);
      send_message(msg);
      n_random++;
    end

    @(negedge clk_i);
    push <= 1'b0;
    while (parse_results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d messages in %0d bytes: %0d parsed, %0d of them with a length field",
             n_msgs, n_bytes, n_ok, n_clen);
    $display("directed cases, a full result queue behind a long hold-off, %0d random",
             n_random);
    if (mismatches == 0) begin
      $display("http_response_header_parser: match");
    end else begin
      $display("http_response_header_parser: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
src/hrhp_pkg.sv
src/hrhp_front.sv
src/hrhp_queue.sv
src/hrhp_back.sv
src/http_response_header_parser.sv
src/hrhp_checker.sv
verif/tb_http_response_header_parser.sv
